FILE: rtl/rvmdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvmdu_pkg
// shared types and constants of the rv64 multiply / divide unit
// ----------------------------------------------------------------------------
package rvmdu_pkg;

    localparam int XLEN      = 64;
    localparam int HALF      = XLEN / 2;
    localparam int DIV_STEPS = XLEN;

    typedef enum logic [3:0] {
        OP_MUL    = 4'd0,
        OP_MULH   = 4'd1,
        OP_MULHSU = 4'd2,
        OP_MULHU  = 4'd3,
        OP_DIV    = 4'd4,
        OP_DIVU   = 4'd5,
        OP_REM    = 4'd6,
        OP_REMU   = 4'd7,
        OP_MULW   = 4'd8,
        OP_DIVW   = 4'd9,
        OP_DIVUW  = 4'd10,
        OP_REMW   = 4'd11,
        OP_REMUW  = 4'd12
    } op_t;

    // request context that travels with every item
    typedef struct packed {
        logic [3:0]      op;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic            is_word;
        logic            dz;
        logic            neg_q;
        logic            neg_r;
        logic [XLEN-1:0] mul_res;
    } ctl_t;

    // restoring divider state
    typedef struct packed {
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] dsr;
    } div_t;

    // 32x32 partial products of the unsigned operands
    typedef struct packed {
        logic [XLEN-1:0] ll;
        logic [XLEN-1:0] lh;
        logic [XLEN-1:0] hl;
        logic [XLEN-1:0] hh;
    } pp_t;

    function automatic logic [XLEN-1:0] sx32(input logic [HALF-1:0] v);
        sx32 = {{HALF{v[HALF-1]}}, v};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rvmdu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvmdu_front
// first stage: decode, divide operand magnitudes and multiplier partial products
// ----------------------------------------------------------------------------
module rvmdu_front
    import rvmdu_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [3:0]      req_type,
    input  wire logic [XLEN-1:0] operand_a,
    input  wire logic [XLEN-1:0] operand_b,
    output logic                 out_valid,
    output ctl_t                 out_ctl,
    output div_t                 out_div,
    output pp_t                  out_pp
);

    logic            valid_reg;
    ctl_t            ctl_reg, ctl_next;
    div_t            div_reg, div_next;
    pp_t             pp_reg, pp_next;
    logic            sgn;
    logic            na;
    logic            nb;
    logic [XLEN-1:0] a_n;
    logic [XLEN-1:0] b_n;

    always_comb
    begin
        ctl_next.is_word = (req_type == OP_MULW) || (req_type == OP_DIVW) ||
                           (req_type == OP_DIVUW) || (req_type == OP_REMW) ||
                           (req_type == OP_REMUW);
        sgn = (req_type == OP_DIV) || (req_type == OP_REM) ||
              (req_type == OP_DIVW) || (req_type == OP_REMW);
        na  = sgn && (ctl_next.is_word ? operand_a[HALF-1] : operand_a[XLEN-1]);
        nb  = sgn && (ctl_next.is_word ? operand_b[HALF-1] : operand_b[XLEN-1]);
        a_n = -operand_a;
        b_n = -operand_b;

        ctl_next.op      = req_type;
        ctl_next.a       = operand_a;
        ctl_next.b       = operand_b;
        ctl_next.dz      = ctl_next.is_word ? (operand_b[HALF-1:0] == '0)
                                            : (operand_b == '0);
        ctl_next.neg_q   = na ^ nb;
        ctl_next.neg_r   = na;
        ctl_next.mul_res = '0;

        // word forms divide the 32-bit magnitudes, zero-extended
        div_next.rem = '0;
        if (ctl_next.is_word)
        begin
            div_next.quo = {{HALF{1'b0}}, na ? a_n[HALF-1:0] : operand_a[HALF-1:0]};
            div_next.dsr = {{HALF{1'b0}}, nb ? b_n[HALF-1:0] : operand_b[HALF-1:0]};
        end
        else
        begin
            div_next.quo = na ? a_n : operand_a;
            div_next.dsr = nb ? b_n : operand_b;
        end

        pp_next.ll = operand_a[HALF-1:0] * operand_b[HALF-1:0];
        pp_next.lh = operand_a[HALF-1:0] * operand_b[XLEN-1:HALF];
        pp_next.hl = operand_a[XLEN-1:HALF] * operand_b[HALF-1:0];
        pp_next.hh = operand_a[XLEN-1:HALF] * operand_b[XLEN-1:HALF];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_next;
            div_reg <= div_next;
            pp_reg  <= pp_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_div   = div_reg;
    assign out_pp    = pp_reg;

endmodule
`default_nettype wire

FILE: rtl/rvmdu_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvmdu_mul
// two stages: product sum, then signed high-half correction and select
// ----------------------------------------------------------------------------
module rvmdu_mul
    import rvmdu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire ctl_t in_ctl,
    input  wire div_t in_div,
    input  wire pp_t  in_pp,
    output logic      out_valid,
    output ctl_t      out_ctl,
    output div_t      out_div
);

    logic              v1_reg;
    ctl_t              ctl1_reg;
    div_t              div1_reg;
    logic [2*XLEN-1:0] prod_reg, prod_next;

    logic              v2_reg;
    ctl_t              ctl2_reg, ctl2_next;
    div_t              div2_reg;
    logic [XLEN-1:0]   hu;
    logic [XLEN-1:0]   hsu;
    logic [XLEN-1:0]   hs;

    assign prod_next = {in_pp.hh, in_pp.ll}
                     + {{HALF{1'b0}}, in_pp.lh, {HALF{1'b0}}}
                     + {{HALF{1'b0}}, in_pp.hl, {HALF{1'b0}}};

    always_comb
    begin
        hu  = prod_reg[2*XLEN-1:XLEN];
        hsu = hu - (ctl1_reg.a[XLEN-1] ? ctl1_reg.b : '0);
        hs  = hsu - (ctl1_reg.b[XLEN-1] ? ctl1_reg.a : '0);
        ctl2_next = ctl1_reg;
        case (ctl1_reg.op)
            OP_MUL:    ctl2_next.mul_res = prod_reg[XLEN-1:0];
            OP_MULH:   ctl2_next.mul_res = hs;
            OP_MULHSU: ctl2_next.mul_res = hsu;
            OP_MULHU:  ctl2_next.mul_res = hu;
            OP_MULW:   ctl2_next.mul_res = sx32(prod_reg[HALF-1:0]);
            default:   ctl2_next.mul_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg <= in_ctl;
            div1_reg <= in_div;
            prod_reg <= prod_next;
            ctl2_reg <= ctl2_next;
            div2_reg <= div1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_ctl   = ctl2_reg;
    assign out_div   = div2_reg;

endmodule
`default_nettype wire

FILE: rtl/rvmdu_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvmdu_div_step
// one registered restoring division step, one quotient bit
// ----------------------------------------------------------------------------
module rvmdu_div_step
    import rvmdu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire ctl_t in_ctl,
    input  wire div_t in_div,
    output logic      out_valid,
    output ctl_t      out_ctl,
    output div_t      out_div
);

    logic            valid_reg;
    ctl_t            ctl_reg;
    div_t            div_reg, div_next;
    logic [XLEN:0]   sh;
    logic [XLEN:0]   diff;

    always_comb
    begin
        sh   = {in_div.rem, in_div.quo[XLEN-1]};
        diff = sh - {1'b0, in_div.dsr};
        div_next.dsr = in_div.dsr;
        if (!diff[XLEN])
        begin
            div_next.rem = diff[XLEN-1:0];
            div_next.quo = {in_div.quo[XLEN-2:0], 1'b1};
        end
        else
        begin
            div_next.rem = sh[XLEN-1:0];
            div_next.quo = {in_div.quo[XLEN-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= in_ctl;
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_div   = div_reg;

endmodule
`default_nettype wire

FILE: rtl/rv64_multiply_divide_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv64_multiply_divide_unit
// rv64m multiply / divide unit, fully pipelined
// ----------------------------------------------------------------------------
// Every request passes from acceptance to a valid result through one decode
// and partial-product stage, two multiplier stages, 64 restoring divider steps
// of one quotient bit each, and the result register. A new request is taken
// every cycle; the whole pipeline advances together and holds only when the
// result register is full and not being taken. Results leave in request order.
// ----------------------------------------------------------------------------
module rv64_multiply_divide_unit
    import rvmdu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // req_type[3:0], operand_a[67:4], operand_b[131:68]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata   // result[63:0]
);

    logic            adv;
    logic            f_valid;
    ctl_t            f_ctl;
    div_t            f_div;
    pp_t             f_pp;
    logic            d_valid [0:DIV_STEPS];
    ctl_t            d_ctl   [0:DIV_STEPS];
    div_t            d_div   [0:DIV_STEPS];
    ctl_t            lc;
    logic [XLEN-1:0] qv;
    logic [XLEN-1:0] rv;
    logic            out_valid_reg;
    logic [XLEN-1:0] out_data_reg, out_data_next;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    rvmdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_axis_tvalid),
        .req_type  (s_axis_tdata[3:0]),
        .operand_a (s_axis_tdata[67:4]),
        .operand_b (s_axis_tdata[131:68]),
        .out_valid (f_valid),
        .out_ctl   (f_ctl),
        .out_div   (f_div),
        .out_pp    (f_pp)
    );

    rvmdu_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f_valid),
        .in_ctl    (f_ctl),
        .in_div    (f_div),
        .in_pp     (f_pp),
        .out_valid (d_valid[0]),
        .out_ctl   (d_ctl[0]),
        .out_div   (d_div[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        rvmdu_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (d_valid[i]),
            .in_ctl    (d_ctl[i]),
            .in_div    (d_div[i]),
            .out_valid (d_valid[i+1]),
            .out_ctl   (d_ctl[i+1]),
            .out_div   (d_div[i+1])
        );
    end

    // result select, sign fixup, divide-by-zero and word sign extension
    always_comb
    begin
        lc = d_ctl[DIV_STEPS];
        qv = lc.neg_q ? -d_div[DIV_STEPS].quo : d_div[DIV_STEPS].quo;
        rv = lc.neg_r ? -d_div[DIV_STEPS].rem : d_div[DIV_STEPS].rem;
        case (lc.op) inside
            OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_MULW:
                out_data_next = lc.mul_res;
            OP_DIV, OP_DIVU:
                out_data_next = lc.dz ? '1 : qv;
            OP_REM, OP_REMU:
                out_data_next = lc.dz ? lc.a : rv;
            OP_DIVW, OP_DIVUW:
                out_data_next = lc.dz ? '1 : sx32(qv[HALF-1:0]);
            OP_REMW, OP_REMUW:
                out_data_next = lc.dz ? sx32(lc.a[HALF-1:0]) : sx32(rv[HALF-1:0]);
            default:
                out_data_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stall");

    a_front_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(f_valid) && $stable(d_valid[DIV_STEPS]))
        else $error("pipeline moved while stalled");

    a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(d_valid[DIV_STEPS]))
        else $error("result valid without item in last divider step");

    a_accept_enters_front: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> f_valid)
        else $error("accepted request lost at entry");
`endif

endmodule
`default_nettype wire
